// ===== sv/sse_pkg.sv =====
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the shell sort engine
// value word type and order mode codes used by the channels and the core
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int VALUE_W = 32;
  localparam int MODE_W  = 2;

  // signed q16.16 value word
  typedef logic signed [VALUE_W-1:0] value_t;

  // order mode register
  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ASC  = 2'd0;
  localparam mode_t MODE_DESC = 2'd1;
  localparam mode_t MODE_REV  = 2'd2;

endpackage

// ===== sv/sse_sample_if.sv =====
// ----------------------------------------------------------------------------
// sse_sample_if: input channel of the shell sort engine
// one value word per handshake, with a mark on the last word of a set
// ----------------------------------------------------------------------------
interface sse_sample_if;
  import sse_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);

endinterface

// ===== sv/sse_result_if.sv =====
// ----------------------------------------------------------------------------
// sse_result_if: output channel of the shell sort engine
// one ordered word per handshake, with end of set and overflow marks
// ----------------------------------------------------------------------------
interface sse_result_if;
  import sse_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_set;
  logic   overflow_seen;

  modport source (output valid, output sorted_value, output end_of_set,
                  output overflow_seen, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set,
                  input overflow_seen, output ready);

endinterface

// ===== sv/sse_ram.sv =====
// ----------------------------------------------------------------------------
// sse_ram: generic simple dual port ram
// one write port, one read port with registered read data (old data on
// a read of the entry being written)
// ----------------------------------------------------------------------------
module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/shell_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// shell_sort_engine_core: load, shell sort (ascending and descending modes) and emit of a set of values
//
//   channel   | dir | word                                       | handshake
//   ----------+-----+--------------------------------------------+-------------
//   samples   | in  | sample_value, final_item                   | valid/ready
//   results   | out | sorted_value, end_of_set, overflow_seen    | valid/ready
//   cfg       | in  | cfg_wdata (order mode)                     | cfg_we
//
// load takes one word per cycle; samples.ready is high only in the load phase.
// the sort is an insertion pass per gap over one ram: ST_RDI and ST_HOLD fetch
// each element, ST_CMP shifts one greater entry per visit, ST_CMP or ST_PLACE
// places it; emission reads each word in ST_ERD and registers it in ST_ELD.
// a stalled results channel holds the emit sequencer in place.
// rst clears the count, the drop flag and the mode; the store is not cleared.
// ----------------------------------------------------------------------------
module shell_sort_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  sse_pkg::mode_t  cfg_wdata,
  sse_sample_if.sink      samples,
  sse_result_if.source    results
);
  import sse_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_RDI   = 7'b0000010,
    ST_HOLD  = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_PLACE = 7'b0010000,
    ST_ERD   = 7'b0100000,
    ST_ELD   = 7'b1000000
  } state_t;

  state_t          state, state_next;
  mode_t           order_mode;
  logic [CW-1:0]   cnt, cnt_next;
  logic            dropped, dropped_next;
  logic            emit_rev, emit_rev_next;
  logic [AW-1:0]   gap, gap_next;
  logic [AW-1:0]   i, i_next;
  logic [AW-1:0]   j, j_next;
  logic [AW-1:0]   k, k_next;
  value_t          held, held_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic            out_valid;
  value_t          out_value;
  logic            out_eos;
  logic            out_ov;
  logic            out_load;
  logic            eos_c;

  logic            accept;
  logic            room;
  logic [CW-1:0]   n_after;
  logic [AW-1:0]   jg;
  logic [AW-1:0]   gap_half;
  logic [CW-1:0]   nm1;
  logic [AW-1:0]   eaddr;

  // value store
  sse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared datapath terms
  assign accept   = samples.valid && samples.ready;
  assign room     = cnt < CAP_C;
  assign n_after  = room ? cnt + CW'(1) : cnt;
  assign jg       = j - gap;
  assign gap_half = gap >> 1;
  assign nm1      = cnt - CW'(1);
  assign eaddr    = emit_rev ? (AW'(nm1) - k) : k;
  assign eos_c    = CW'(k) == nm1;
  assign out_load = !out_valid || results.ready;

  assign samples.ready = (state == ST_LOAD);

  // order mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= MODE_ASC;
    end else if (cfg_we) begin
      order_mode <= cfg_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    dropped_next  = dropped;
    emit_rev_next = emit_rev;
    gap_next      = gap;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    held_next     = held;
    ram_we        = 1'b0;
    ram_waddr     = j;
    ram_wdata     = held;
    ram_raddr     = i;

    unique case (state)
      ST_LOAD: begin
        ram_waddr = AW'(cnt);
        ram_wdata = samples.sample_value;
        if (accept) begin
          ram_we       = room;
          cnt_next     = n_after;
          dropped_next = dropped || !room;
          if (samples.final_item) begin
            emit_rev_next = (order_mode == MODE_DESC) || (order_mode == MODE_REV);
            k_next        = '0;
            if (((order_mode == MODE_ASC) || (order_mode == MODE_DESC)) &&
                (n_after > CW'(1))) begin
              gap_next   = AW'(n_after >> 1);
              i_next     = AW'(n_after >> 1);
              state_next = ST_RDI;
            end else begin
              state_next = ST_ERD;
            end
          end
        end
      end

      // fetch element i
      ST_RDI: begin
        ram_raddr  = i;
        state_next = ST_HOLD;
      end

      // hold element i and fetch its gap neighbor
      ST_HOLD: begin
        held_next  = $signed(ram_rdata);
        j_next     = i;
        ram_raddr  = i - gap;
        state_next = ST_CMP;
      end

      // shift the neighbor up while it is greater than the held value, else place the held value
      ST_CMP: begin
        ram_we = 1'b1;
        if ($signed(ram_rdata) > held) begin
          ram_wdata = ram_rdata;
          j_next    = jg;
          ram_raddr = jg - gap;
          if (jg >= gap) begin
            state_next = ST_CMP;
          end else begin
            state_next = ST_PLACE;
          end
        end else begin
          ram_wdata = held;
          if ((CW'(i) + CW'(1)) < cnt) begin
            i_next     = i + AW'(1);
            state_next = ST_RDI;
          end else if (gap_half != '0) begin
            gap_next   = gap_half;
            i_next     = gap_half;
            state_next = ST_RDI;
          end else begin
            state_next = ST_ERD;
          end
        end
      end

      // place the held value at the end of its shift run
      ST_PLACE: begin
        ram_we = 1'b1;
        if ((CW'(i) + CW'(1)) < cnt) begin
          i_next     = i + AW'(1);
          state_next = ST_RDI;
        end else if (gap_half != '0) begin
          gap_next   = gap_half;
          i_next     = gap_half;
          state_next = ST_RDI;
        end else begin
          state_next = ST_ERD;
        end
      end

      // fetch the next word to emit
      ST_ERD: begin
        ram_raddr  = eaddr;
        state_next = ST_ELD;
      end

      // move it to the output register once that is free
      ST_ELD: begin
        ram_raddr = eaddr;
        if (out_load) begin
          if (eos_c) begin
            cnt_next     = '0;
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            k_next     = k + AW'(1);
            state_next = ST_ERD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      cnt     <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    emit_rev <= emit_rev_next;
    gap      <= gap_next;
    i        <= i_next;
    j        <= j_next;
    k        <= k_next;
    held     <= held_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_ELD) && out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_ELD) && out_load) begin
      out_value <= $signed(ram_rdata);
      out_eos   <= eos_c;
      out_ov    <= dropped;
    end
  end

  assign results.valid         = out_valid;
  assign results.sorted_value  = out_value;
  assign results.end_of_set    = out_eos;
  assign results.overflow_seen = out_ov;

`ifndef SYNTHESIS
  // sort writes stay inside the loaded set
  a_sort_write_in_set: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state != ST_LOAD)) |-> (CW'(ram_waddr) < cnt))
    else $error("sort write outside loaded set");

  // the insertion cursor never runs below the gap
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> ((j >= gap) && (CW'(j) < cnt) && (gap != '0)))
    else $error("insertion cursor out of range");

  // the last word of a set returns the block to an empty load phase
  a_set_done: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ELD) && out_load && eos_c) |=>
      ((state == ST_LOAD) && (cnt == '0) && !dropped && results.end_of_set))
    else $error("set not cleared after last word");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the shell sort engine core
// loads sets of q16.16 words, predicts the emitted order for every order
// mode (ascending, descending, reversed, unused code kept in load order) and
// checks each emitted word with its end and overflow marks, under random
// stalls on both channels and with sets that overrun the store
// ----------------------------------------------------------------------------
module tb_top;
  import sse_pkg::*;

  localparam int          SET_CAP    = 16;
  localparam int          SETTLE     = 8;
  localparam int          WORD_GOAL  = 430;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int          PRINT_CAP  = 100;
  // unused mode code, emits the set as loaded
  localparam mode_t       MODE_KEEP  = 2'd3;
  localparam value_t      VAL_MIN    = 32'sh8000_0000;
  localparam value_t      VAL_MAX    = 32'sh7fff_ffff;

  typedef struct {
    value_t value;
    logic   last;
    logic   dropped;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  mode_t cfg_wdata = MODE_ASC;

  sse_sample_if smp();
  sse_result_if res();

  shell_sort_engine_core #(.CAPACITY(SET_CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .samples   (smp),
    .results   (res)
  );

  // predictor state: words of the set being loaded, drop mark, order mode
  value_t    loaded[$];
  logic      dropped = 1'b0;
  mode_t     order_mode = MODE_ASC;
  out_word_t ordered_words[$];

  int          mismatches = 0;
  int          words_sent = 0;
  int          max_send_gap = 19;
  int          max_stall = 19;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // load one word; a final word orders the set and queues the emitted words
  function automatic void take_sample(input value_t v, input logic fin);
    value_t work[SET_CAP];
    value_t held;
    int     n;
    int     gap;
    int     i;
    int     j;
    if (loaded.size() < SET_CAP) loaded.push_back(v);
    else dropped = 1'b1;
    if (!fin) return;
    n = loaded.size();
    for (i = 0; i < n; i++) work[i] = loaded[i];
    // insertion pass per gap, gaps halving from n/2
    if (order_mode == MODE_ASC || order_mode == MODE_DESC) begin
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
        for (i = gap; i < n; i++) begin
          held = work[i];
          j = i;
          while (j >= gap && work[j - gap] > held) begin
            work[j] = work[j - gap];
            j -= gap;
          end
          work[j] = held;
        end
      end
    end
    if (order_mode == MODE_DESC || order_mode == MODE_REV) begin
      for (i = 0; i < n / 2; i++) begin
        held = work[i];
        work[i] = work[n - 1 - i];
        work[n - 1 - i] = held;
      end
    end
    for (i = 0; i < n; i++) ordered_words.push_back('{work[i], i == n - 1, dropped});
    loaded.delete();
    dropped = 1'b0;
  endfunction

  // send one word after a random gap; returns at the accepting edge
  task automatic send_word(input value_t v, input logic fin);
    int gap;
    gap = $urandom_range(0, max_send_gap);
    @(negedge clk);
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_value <= v;
    smp.final_item <= fin;
    @(posedge clk);
    while (smp.ready !== 1'b1) @(posedge clk);
    take_sample(v, fin);
    words_sent++;
  endtask

  // hold the sender until every queued word has been emitted
  task automatic wait_for_results();
    @(negedge clk);
    smp.valid <= 1'b0;
    while (ordered_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mode write, only while the core is idle
  task automatic set_order(input mode_t m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    order_mode = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic value_t pick_sample();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: return value_t'($urandom_range(0, 6)) - 32'sd3;
      default: return value_t'($urandom);
    endcase
  endfunction

  // result sink: random stall per word, compare with the oldest expectation
  initial begin : result_sink
    int        stall;
    out_word_t want;
    res.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = $urandom_range(0, max_stall);
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (res.valid !== 1'b1) @(posedge clk);
      if (ordered_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", res.sorted_value));
      end else begin
        want = ordered_words.pop_front();
        if (res.sorted_value !== want.value)
          report_mismatch($sformatf("sorted_value %h, want %h", res.sorted_value, want.value));
        if (res.end_of_set !== want.last)
          report_mismatch($sformatf("end_of_set %b, want %b", res.end_of_set, want.last));
        if (res.overflow_seen !== want.dropped)
          report_mismatch($sformatf("overflow_seen %b, want %b", res.overflow_seen,
                                    want.dropped));
      end
      @(negedge clk);
    end
  end

  // one-word sets at both ends of the range
  task automatic test_single_word();
    send_word(VAL_MIN, 1'b1);
    send_word(VAL_MAX, 1'b1);
    wait_for_results();
  endtask

  // same small set with duplicates and extremes in every mode
  task automatic test_order_modes();
    value_t vals[5];
    mode_t  modes[4];
    vals = '{32'sd0, VAL_MAX, -32'sd1, VAL_MIN, -32'sd1};
    modes = '{MODE_ASC, MODE_DESC, MODE_REV, MODE_KEEP};
    foreach (modes[m]) begin
      set_order(modes[m]);
      foreach (vals[k]) send_word(vals[k], k == 4);
      wait_for_results();
    end
  endtask

  // full store, dropped final word, long overrun; no idling on either side
  task automatic test_capacity_limit();
    int sizes[3];
    sizes = '{SET_CAP, SET_CAP + 1, SET_CAP + 4};
    max_send_gap = 0;
    max_stall = 0;
    set_order(MODE_ASC);
    foreach (sizes[s]) begin
      for (int k = 0; k < sizes[s]; k++) send_word(pick_sample(), k == sizes[s] - 1);
    end
    wait_for_results();
  endtask

  // random sets, random mode changes between sets, random idling profiles
  task automatic test_random_sets();
    int n;
    while (words_sent < WORD_GOAL) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
        set_order(mode_t'($urandom_range(0, 3)));
      end
      max_send_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
      max_stall = ($urandom_range(0, 3) == 0) ? 0 : 19;
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(SET_CAP + 1, SET_CAP + 6)
                                      : $urandom_range(1, SET_CAP);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 63) == 0) wait_for_results();
        send_word(pick_sample(), k == n - 1);
      end
    end
  endtask

  // main sequence
  initial begin
    smp.valid = 1'b0;
    smp.sample_value = '0;
    smp.final_item = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_word();
    test_order_modes();
    test_capacity_limit();
    test_random_sets();
    wait_for_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && ordered_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
